/* hw/rtl/ssa_pkg.sv */
// Shared constants, codes and types of the skipfield slot allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package ssa_pkg;

  localparam int HANDLE_W = 11;
  localparam int FUNC_W = 2;
  localparam int STATUS_W = 2;
  localparam int SLOTS_DEF = 1024;

  // Request codes.
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SCAN = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADH = 2'd2;

  // Datapath commands.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP = 5'd0;
  localparam logic [OP_W-1:0] OP_CLR = 5'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 5'd2;
  localparam logic [OP_W-1:0] OP_FULL = 5'd3;
  localparam logic [OP_W-1:0] OP_BADH = 5'd4;
  localparam logic [OP_W-1:0] OP_ALC0 = 5'd5;
  localparam logic [OP_W-1:0] OP_ALC1 = 5'd6;
  localparam logic [OP_W-1:0] OP_ALC2 = 5'd7;
  localparam logic [OP_W-1:0] OP_ALC3 = 5'd8;
  localparam logic [OP_W-1:0] OP_ALC4 = 5'd9;
  localparam logic [OP_W-1:0] OP_UNL = 5'd10;
  localparam logic [OP_W-1:0] OP_PSH1 = 5'd11;
  localparam logic [OP_W-1:0] OP_PSH2 = 5'd12;
  localparam logic [OP_W-1:0] OP_REL0 = 5'd13;
  localparam logic [OP_W-1:0] OP_REL1 = 5'd14;
  localparam logic [OP_W-1:0] OP_REL2 = 5'd15;
  localparam logic [OP_W-1:0] OP_REL3 = 5'd16;
  localparam logic [OP_W-1:0] OP_MRG0 = 5'd17;
  localparam logic [OP_W-1:0] OP_MRG1 = 5'd18;
  localparam logic [OP_W-1:0] OP_MRG2 = 5'd19;
  localparam logic [OP_W-1:0] OP_MRG3 = 5'd20;
  localparam logic [OP_W-1:0] OP_MRG4 = 5'd21;
  localparam logic [OP_W-1:0] OP_MRG5 = 5'd22;
  localparam logic [OP_W-1:0] OP_SCN0 = 5'd23;
  localparam logic [OP_W-1:0] OP_SCN1 = 5'd24;
  localparam logic [OP_W-1:0] OP_OUT = 5'd25;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] fn;
    logic h_zero;
    logic h_gt;
    logic h_eq;
    logic head_bad;
    logic alc_bad;
    logic alc_more;
    logic val_zero;
    logic r_ok;
    logic on;
    logic bef_ne;
    logic clr_last;
  } sts_t;

endpackage

/* hw/rtl/ssa_ctrl.sv */
// Sequencing controller of the skipfield slot allocator.
// Depends on ssa_pkg for command codes and the status struct.
module ssa_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  ssa_pkg::sts_t             sts,
  output logic [ssa_pkg::OP_W-1:0]  cmd
);
  import ssa_pkg::*;

  localparam logic [4:0] S_CLR = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DEC = 5'd2;
  localparam logic [4:0] S_FULL = 5'd3;
  localparam logic [4:0] S_BADH = 5'd4;
  localparam logic [4:0] S_ALC0 = 5'd5;
  localparam logic [4:0] S_ALC1 = 5'd6;
  localparam logic [4:0] S_ALC2 = 5'd7;
  localparam logic [4:0] S_ALC3 = 5'd8;
  localparam logic [4:0] S_ALC4 = 5'd9;
  localparam logic [4:0] S_UNL = 5'd10;
  localparam logic [4:0] S_PSH1 = 5'd11;
  localparam logic [4:0] S_PSH2 = 5'd12;
  localparam logic [4:0] S_REL0 = 5'd13;
  localparam logic [4:0] S_REL1 = 5'd14;
  localparam logic [4:0] S_REL2 = 5'd15;
  localparam logic [4:0] S_REL3 = 5'd16;
  localparam logic [4:0] S_MRG0 = 5'd17;
  localparam logic [4:0] S_MRG1 = 5'd18;
  localparam logic [4:0] S_MRG2 = 5'd19;
  localparam logic [4:0] S_MRG3 = 5'd20;
  localparam logic [4:0] S_MRG4 = 5'd21;
  localparam logic [4:0] S_MRG5 = 5'd22;
  localparam logic [4:0] S_SCN0 = 5'd23;
  localparam logic [4:0] S_SCN1 = 5'd24;
  localparam logic [4:0] S_DONE = 5'd25;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_free;
  logic       is_rel;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign is_rel = (sts.fn == FN_RELEASE);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  if (sts.clr_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_DEC;
      S_DEC: begin
        case (sts.fn)
          FN_ALLOC:   state_next = sts.head_bad ? S_FULL : S_ALC0;
          FN_RELEASE: state_next = (sts.h_zero || sts.h_gt) ? S_BADH : S_REL0;
          FN_SCAN: begin
            if (sts.h_gt) state_next = S_BADH;
            else if (sts.h_eq) state_next = S_DONE;
            else state_next = S_SCN0;
          end
          default:    state_next = S_DONE;
        endcase
      end
      S_FULL: state_next = S_DONE;
      S_BADH: state_next = S_DONE;
      S_ALC0: state_next = S_ALC1;
      S_ALC1: state_next = sts.alc_bad ? S_FULL : S_ALC2;
      S_ALC2: state_next = S_ALC3;
      S_ALC3: state_next = S_UNL;
      S_UNL:  state_next = is_rel ? S_MRG2 : S_ALC4;
      S_ALC4: state_next = sts.alc_more ? S_PSH1 : S_DONE;
      S_PSH1: begin
        if (sts.on) state_next = is_rel ? S_MRG0 : S_DONE;
        else state_next = S_PSH2;
      end
      S_PSH2: state_next = is_rel ? S_MRG0 : S_DONE;
      S_REL0: state_next = S_REL1;
      S_REL1: state_next = sts.val_zero ? S_PSH1 : S_REL2;
      S_REL2: state_next = S_REL3;
      S_REL3: state_next = S_MRG0;
      S_MRG0: state_next = sts.r_ok ? S_MRG1 : S_DONE;
      S_MRG1: state_next = sts.val_zero ? S_DONE : S_UNL;
      S_MRG2: state_next = S_MRG3;
      S_MRG3: state_next = S_MRG4;
      S_MRG4: state_next = sts.bef_ne ? S_MRG5 : S_DONE;
      S_MRG5: state_next = S_DONE;
      S_SCN0: state_next = S_SCN1;
      S_SCN1: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Command to the datapath for the current state.
  always_comb begin
    case (state)
      S_CLR:  cmd = OP_CLR;
      S_IDLE: cmd = in_valid ? OP_LOAD : OP_NOP;
      S_FULL: cmd = OP_FULL;
      S_BADH: cmd = OP_BADH;
      S_ALC0: cmd = OP_ALC0;
      S_ALC1: cmd = OP_ALC1;
      S_ALC2: cmd = OP_ALC2;
      S_ALC3: cmd = OP_ALC3;
      S_ALC4: cmd = OP_ALC4;
      S_UNL:  cmd = OP_UNL;
      S_PSH1: cmd = OP_PSH1;
      S_PSH2: cmd = OP_PSH2;
      S_REL0: cmd = OP_REL0;
      S_REL1: cmd = OP_REL1;
      S_REL2: cmd = OP_REL2;
      S_REL3: cmd = OP_REL3;
      S_MRG0: cmd = OP_MRG0;
      S_MRG1: cmd = OP_MRG1;
      S_MRG2: cmd = OP_MRG2;
      S_MRG3: cmd = OP_MRG3;
      S_MRG4: cmd = OP_MRG4;
      S_MRG5: cmd = OP_MRG5;
      S_SCN0: cmd = OP_SCN0;
      S_SCN1: cmd = OP_SCN1;
      S_DONE: cmd = out_free ? OP_OUT : OP_NOP;
      default: cmd = OP_NOP;
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result raised outside done");
  a_done_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> (state == S_IDLE || state == S_DONE)) else $error("bad exit from done");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_DEC) else $error("accepted item not decoded");

endmodule

/* hw/rtl/ssa_datapath.sv */
// Datapath of the skipfield slot allocator: skip, membership and link memories,
// the free-list head, working registers and the result register. Uses ssa_pkg.
module ssa_datapath #(
  parameter int SLOTS = ssa_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ssa_pkg::FUNC_W-1:0]    func,
  input  logic [ssa_pkg::HANDLE_W-1:0]  handle,
  input  logic [ssa_pkg::OP_W-1:0]      cmd,
  output ssa_pkg::sts_t                 sts,
  output logic [ssa_pkg::HANDLE_W-1:0]  handle_out,
  output logic [ssa_pkg::STATUS_W-1:0]  status,
  output logic                          free_available
);
  import ssa_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int VW = $clog2(SLOTS + 1);
  localparam int CW = ((HANDLE_W > VW) ? HANDLE_W : VW) + 1;
  localparam logic [CW-1:0] SL = CW'(SLOTS);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [VW-1:0] VMAX = VW'(SLOTS);

  function automatic logic [VW-1:0] sat(input logic [CW-1:0] v);
    return (v > SL) ? VMAX : v[VW-1:0];
  endfunction

  // Memories.
  logic [VW-1:0] skip_mem [SLOTS];
  logic          on_mem [SLOTS];
  logic [VW-1:0] next_mem [SLOTS];
  logic [VW-1:0] prev_mem [SLOTS];

  // Working registers.
  logic [FUNC_W-1:0]   fn;
  logic [CW-1:0]       h, x, y, u, p, bef;
  logic [VW-1:0]       len, v2, tot, head;
  logic [HANDLE_W-1:0] res;
  logic [STATUS_W-1:0] st;
  logic [IW-1:0]       cnt;
  logic [VW-1:0]       sk_q, pl_q, nl_q;
  logic                sk_oob, on_q;

  logic [VW-1:0] sk_val, ev, sv, tsum;
  logic [CW-1:0] e_c, start_c, x1, scan_t, headm1, sra, lra_c, swa;
  logic [VW-1:0] swd;
  logic          sw_en;
  logic [CW-1:0] pm1, nm1;

  assign sk_val = sk_oob ? '0 : sk_q;
  assign e_c = x + CW'(sk_val) - ONE;
  assign start_c = x - CW'(sk_val);
  assign ev = (sk_val == '0) ? VMAX : sk_val - VW'(1);
  assign sv = sat(CW'(sk_val) + ONE);
  assign tsum = sat(CW'(sk_val) + CW'(len));
  assign x1 = x + ONE;
  assign scan_t = h + CW'(sk_val);
  assign headm1 = CW'(head) - ONE;
  assign pm1 = CW'(pl_q) - ONE;
  assign nm1 = CW'(nl_q) - ONE;

  // Status flags.
  always_comb begin
    sts.fn = fn;
    sts.h_zero = (h == '0);
    sts.h_gt = (h > SL);
    sts.h_eq = (h == SL);
    sts.head_bad = (head == '0) || (headm1 >= SL);
    sts.alc_bad = (sk_val == '0) || (e_c >= SL);
    sts.alc_more = (len > VW'(1)) && (x1 < SL);
    sts.val_zero = (sk_val == '0);
    sts.r_ok = (x1 < SL);
    sts.on = on_q;
    sts.bef_ne = (bef != x);
    sts.clr_last = (cnt == IW'(SLOTS - 1));
  end

  // Read addresses.
  always_comb begin
    case (cmd)
      OP_ALC0: sra = headm1;
      OP_ALC1: sra = e_c;
      OP_REL0: sra = h - CW'(2);
      OP_REL1: sra = start_c;
      OP_MRG0: sra = x1;
      OP_MRG2: sra = bef;
      OP_SCN0: sra = h;
      default: sra = '0;
    endcase
    case (cmd)
      OP_ALC4: lra_c = x1;
      OP_MRG1: lra_c = x1;
      default: lra_c = x;
    endcase
  end

  // Skip store write port.
  always_comb begin
    sw_en = 1'b1;
    swa = x;
    swd = '0;
    case (cmd)
      OP_CLR: begin
        swa = CW'(cnt);
        swd = (cnt == '0 || cnt == IW'(SLOTS - 1)) ? VMAX : '0;
      end
      OP_ALC2: begin
        swa = y;
        swd = ev;
      end
      OP_ALC3: swd = '0;
      OP_ALC4: begin
        swa = x1;
        swd = v2;
        sw_en = sts.alc_more;
      end
      OP_REL1: begin
        swd = VW'(1);
        sw_en = sts.val_zero;
      end
      OP_REL2: begin
        swa = y;
        swd = sv;
      end
      OP_REL3: swd = v2;
      OP_MRG3: begin
        swa = bef;
        swd = tsum;
      end
      OP_MRG4: begin
        swa = y;
        swd = tot;
      end
      OP_MRG5: swd = '0;
      default: sw_en = 1'b0;
    endcase
  end

  // Skip store.
  always_ff @(posedge clk) begin
    if (sw_en && swa < SL) skip_mem[swa[IW-1:0]] <= swd;
    sk_q <= skip_mem[sra[IW-1:0]];
    sk_oob <= (sra >= SL);
  end

  // Membership and link memories.
  always_ff @(posedge clk) begin
    on_q <= on_mem[lra_c[IW-1:0]];
    pl_q <= prev_mem[lra_c[IW-1:0]];
    nl_q <= next_mem[lra_c[IW-1:0]];
    case (cmd)
      OP_CLR: on_mem[cnt] <= (cnt == '0);
      OP_UNL: begin
        if (on_q) begin
          on_mem[u[IW-1:0]] <= 1'b0;
          if (pl_q != '0 && pm1 < SL) next_mem[pm1[IW-1:0]] <= nl_q;
          if (nl_q != '0 && nm1 < SL) prev_mem[nm1[IW-1:0]] <= pl_q;
        end
      end
      OP_PSH1: begin
        if (!on_q) begin
          on_mem[p[IW-1:0]] <= 1'b1;
          prev_mem[p[IW-1:0]] <= '0;
          next_mem[p[IW-1:0]] <= head;
        end
      end
      OP_PSH2: begin
        if (head != '0 && headm1 < SL) prev_mem[headm1[IW-1:0]] <= VW'(p + ONE);
      end
      default: ;
    endcase
  end

  // Control registers: clear counter and free-list head.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      head <= VW'(1);
    end else begin
      if (cmd == OP_CLR) cnt <= cnt + IW'(1);
      if (cmd == OP_UNL && on_q && pl_q == '0) head <= nl_q;
      if (cmd == OP_PSH2) head <= VW'(p + ONE);
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    case (cmd)
      OP_LOAD: begin
        fn <= func;
        h <= CW'(handle);
        res <= '0;
        st <= ST_OK;
      end
      OP_FULL: st <= ST_FULL;
      OP_BADH: st <= ST_BADH;
      OP_ALC0: x <= headm1;
      OP_ALC1: begin
        len <= sk_val;
        y <= e_c;
      end
      OP_ALC2: v2 <= ev;
      OP_ALC3: begin
        u <= x;
        res <= HANDLE_W'(x1);
      end
      OP_ALC4: p <= x1;
      OP_REL0: x <= h - ONE;
      OP_REL1: begin
        y <= start_c;
        p <= x;
        v2 <= VW'(1);
      end
      OP_REL2: v2 <= (y < SL) ? sv : '0;
      OP_MRG1: begin
        len <= sk_val;
        y <= x + CW'(sk_val);
        u <= x1;
        bef <= (v2 > VW'(1)) ? x - (CW'(v2) - ONE) : x;
      end
      OP_MRG3: tot <= tsum;
      OP_SCN1: res <= (scan_t >= SL) ? '0 : HANDLE_W'(scan_t + ONE);
      OP_OUT: begin
        handle_out <= res;
        status <= st;
        free_available <= (head != '0);
      end
      default: ;
    endcase
  end

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    CW'(head) <= SL) else $error("free-list head beyond pool");
  a_push_head: assert property (@(posedge clk) disable iff (rst)
    cmd == OP_PSH2 |=> head != '0) else $error("push left list empty");
  a_free_flag: assert property (@(posedge clk) disable iff (rst)
    cmd == OP_OUT |=> free_available == ($past(head) != '0))
    else $error("free flag disagrees with head");

endmodule

/* hw/rtl/skipfield_slot_allocator_core.sv */
// Skipfield slot allocator: free runs of a slot pool, kept on a linked free list.
// The time from transfer in to result depends on the request kind and on how long out_stall
// holds the result.
// Throughput: one request at a time; the next is taken in the cycle after the previous
// reaches its result register. Each step does at most one read and one write per memory.
// Reset: a clearing pass writes the skip and membership memories; no request is taken
// during it. Uses ssa_pkg, ssa_ctrl and ssa_datapath.
module skipfield_slot_allocator_core #(
  parameter int SLOTS = ssa_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssa_pkg::FUNC_W-1:0]    func,
  input  logic [ssa_pkg::HANDLE_W-1:0]  handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ssa_pkg::HANDLE_W-1:0]  handle_out,
  output logic [ssa_pkg::STATUS_W-1:0]  status,
  output logic                          free_available
);
  import ssa_pkg::*;

  sts_t            sts;
  logic [OP_W-1:0] cmd;

  // Sequencer.
  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Memories and working registers.
  ssa_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .func           (func),
    .handle         (handle),
    .cmd            (cmd),
    .sts            (sts),
    .handle_out     (handle_out),
    .status         (status),
    .free_available (free_available)
  );

endmodule
